// ===== hdl/adsr_pkg.sv =====
// adsr envelope package: item types, register codes, config derivation
package adsr_pkg;

	localparam int unsigned MIN_SEGMENT = 4800;
	localparam int unsigned DIV_BITS = 15;
	localparam int unsigned NUM_W = 35;
	localparam logic [16:0] UNITY = 17'd32768;

	typedef enum logic [2:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_RELEASE = 3'd2,
		REG_SUSTAIN = 3'd3,
		REG_BUFLEN  = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		RG_ATT,
		RG_DEC,
		RG_SUS,
		RG_REL,
		RG_ZERO
	} region_t;

	typedef struct packed {
		logic signed [15:0] sample_in;
		logic [19:0]        sample_index;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic [15:0]        gain;
	} out_item_t;

	typedef struct packed {
		logic [19:0] attack_len;
		logic [19:0] decay_len;
		logic [19:0] release_len;
		logic [15:0] sustain_level;
		logic [19:0] buffer_len;
	} cfg_t;

	typedef struct packed {
		logic [19:0] a;
		logic [19:0] d;
		logic [15:0] s;
		logic [20:0] dend;
		logic [20:0] send;
		logic        rel_ok;
		logic [19:0] span;
	} env_t;

	typedef struct packed {
		region_t            region;
		logic [15:0]        s;
		logic signed [15:0] sample;
	} div_side_t;

	localparam cfg_t CFG_RESET = '{
		attack_len: 20'd4800,
		decay_len: 20'd4800,
		release_len: 20'd4800,
		sustain_level: 16'd16384,
		buffer_len: 20'd48000
	};

	function automatic logic [19:0] seg_len(input logic [19:0] v);
		seg_len = (v == '0) ? 20'(MIN_SEGMENT) : v;
	endfunction

	function automatic env_t derive(input cfg_t c);
		env_t        e;
		logic [19:0] r;
		logic [20:0] nr;
		logic [20:0] nm1;
		e.a = seg_len(c.attack_len);
		e.d = seg_len(c.decay_len);
		r = seg_len(c.release_len);
		e.s = (c.sustain_level > 16'(UNITY)) ? 16'(UNITY) : c.sustain_level;
		e.dend = {1'b0, e.a} + {1'b0, e.d};
		nr = {1'b0, c.buffer_len} - {1'b0, r};
		if (c.buffer_len >= r && nr > e.dend) begin
			e.send = nr;
		end else begin
			e.send = e.dend;
		end
		nm1 = {1'b0, c.buffer_len} - 21'd1;
		e.rel_ok = (c.buffer_len != '0) && (nm1 > e.send);
		e.span = 20'(nm1 - e.send);
		return e;
	endfunction

endpackage

// ===== hdl/adsr_div.sv =====
// adsr envelope pipelined restoring divider, one quotient bit per stage
module adsr_div
	import adsr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [NUM_W-1:0]    num,
	input  logic [19:0]         den,
	input  div_side_t           side_in,
	output logic                out_valid,
	output logic [DIV_BITS-1:0] quo,
	output div_side_t           side_out
);

	logic [DIV_BITS-1:0] valid_s;
	logic [19:0]         rem_s [DIV_BITS];
	logic [DIV_BITS-1:0] lo_s  [DIV_BITS];
	logic [DIV_BITS-1:0] quo_s [DIV_BITS];
	logic [19:0]         den_s [DIV_BITS];
	div_side_t           side_s [DIV_BITS];

	for (genvar j = 0; j < DIV_BITS; j++) begin : g_stage
		logic                v_in;
		logic [19:0]         r_in;
		logic [DIV_BITS-1:0] lo_in;
		logic [DIV_BITS-1:0] q_in;
		logic [19:0]         d_in;
		div_side_t           sd_in;
		logic [20:0]         trial;
		logic [20:0]         diff;
		logic                ge;

		if (j == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = num[NUM_W-1:DIV_BITS];
			assign lo_in = num[DIV_BITS-1:0];
			assign q_in  = '0;
			assign d_in  = den;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = valid_s[j-1];
			assign r_in  = rem_s[j-1];
			assign lo_in = lo_s[j-1];
			assign q_in  = quo_s[j-1];
			assign d_in  = den_s[j-1];
			assign sd_in = side_s[j-1];
		end

		assign trial = {r_in, lo_in[DIV_BITS-1]};
		assign diff  = trial - {1'b0, d_in};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else begin
				valid_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j]  <= ge ? diff[19:0] : trial[19:0];
			lo_s[j]   <= {lo_in[DIV_BITS-2:0], 1'b0};
			quo_s[j]  <= {q_in[DIV_BITS-2:0], ge};
			den_s[j]  <= d_in;
			side_s[j] <= sd_in;
		end
	end

	assign out_valid = valid_s[DIV_BITS-1];
	assign quo       = quo_s[DIV_BITS-1];
	assign side_out  = side_s[DIV_BITS-1];

endmodule

// ===== hdl/adsr_envelope_apply.sv =====
// adsr envelope top level: linear adsr gain and sample scaling pipeline
//
// input: an item (sample and its index in the buffer) is taken on a clock
// edge with start high and busy low. busy is high only in the first cycle
// after reset, so one item can be taken every cycle.
// output: each item gives one result on result, marked by done for one
// cycle, in input order; the receiver cannot hold results off and none
// is needed.
// configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register (attack, decay, release, sustain, buffer length). cfg_ready is
// always high; derived stage bounds are registered in env_q from cfg_q.
// the pipeline is built round the divider, one quotient bit per stage over
// 15 stages, plus input, classify, multiply, gain, product and output stages.
// reset clears the pipeline valid bits and loads the register defaults.
module adsr_envelope_apply
	import adsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        done,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int unsigned LATENCY = 21;

	cfg_t        cfg_q;
	env_t        env_q;
	logic        run_q;

	logic               v_s1;
	logic signed [15:0] smp_s1;
	logic [19:0]        idx_s1;

	logic               v_s2;
	region_t            rg_s2;
	logic [19:0]        t_s2;
	logic [19:0]        dv_s2;
	logic [15:0]        m_s2;
	logic [15:0]        sus_s2;
	logic signed [15:0] smp_s2;

	logic               v_s3;
	logic [NUM_W-1:0]   x_s3;
	logic [19:0]        dv_s3;
	div_side_t          side_s3;

	logic                dv_valid;
	logic [DIV_BITS-1:0] dv_quo;
	div_side_t           dv_side;

	logic               v_s4;
	logic [15:0]        gain_s4;
	logic signed [15:0] smp_s4;

	logic               v_s5;
	logic [15:0]        gain_s5;
	logic signed [32:0] prod_s5;

	logic               done_q;
	out_item_t          result_q;

	region_t     rg_c;
	logic [19:0] t_c;
	logic [19:0] dv_c;
	logic [15:0] m_c;
	logic [15:0] gain_c;
	logic [20:0] idx_w;

	assign cfg_ready = 1'b1;
	assign busy      = !run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
			env_q <= derive(CFG_RESET);
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
			env_q <= derive(cfg_q);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ATTACK:  cfg_q.attack_len    <= cfg_data;
					REG_DECAY:   cfg_q.decay_len     <= cfg_data;
					REG_RELEASE: cfg_q.release_len   <= cfg_data;
					REG_SUSTAIN: cfg_q.sustain_level <= cfg_data[15:0];
					REG_BUFLEN:  cfg_q.buffer_len    <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= dv_valid;
			v_s5   <= v_s4;
			done_q <= v_s5;
		end
	end

	// stage classification
	assign idx_w = {1'b0, idx_s1};

	always_comb begin
		t_c  = idx_s1;
		dv_c = env_q.a;
		m_c  = 16'(UNITY);
		if (idx_s1 < env_q.a) begin
			rg_c = RG_ATT;
		end else if (idx_w < env_q.dend) begin
			rg_c = RG_DEC;
			t_c  = idx_s1 - env_q.a;
			dv_c = env_q.d;
			m_c  = 16'(UNITY - {1'b0, env_q.s});
		end else if (idx_w < env_q.send) begin
			rg_c = RG_SUS;
		end else if (env_q.rel_ok) begin
			rg_c = RG_REL;
			t_c  = 20'(idx_w - env_q.send);
			dv_c = env_q.span;
			m_c  = env_q.s;
		end else begin
			rg_c = RG_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		smp_s1 <= item.sample_in;
		idx_s1 <= item.sample_index;

		rg_s2  <= rg_c;
		t_s2   <= t_c;
		dv_s2  <= dv_c;
		m_s2   <= m_c;
		sus_s2 <= env_q.s;
		smp_s2 <= smp_s1;

		x_s3           <= NUM_W'(t_s2 * m_s2);
		dv_s3          <= dv_s2;
		side_s3.s      <= sus_s2;
		side_s3.sample <= smp_s2;
		if (rg_s2 == RG_REL && t_s2 >= dv_s2) begin
			side_s3.region <= RG_ZERO;
		end else begin
			side_s3.region <= rg_s2;
		end
	end

	adsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.num      (x_s3),
		.den      (dv_s3),
		.side_in  (side_s3),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	always_comb begin
		case (dv_side.region)
			RG_ATT:  gain_c = {1'b0, dv_quo};
			RG_DEC:  gain_c = 16'(UNITY - {2'b0, dv_quo});
			RG_SUS:  gain_c = dv_side.s;
			RG_REL:  gain_c = dv_side.s - {1'b0, dv_quo};
			default: gain_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		gain_s4 <= gain_c;
		smp_s4  <= dv_side.sample;

		gain_s5 <= gain_s4;
		prod_s5 <= smp_s4 * $signed({1'b0, gain_s4});

		result_q.sample_out <= prod_s5[30:15];
		result_q.gain       <= gain_s5;
	end

	assign done   = done_q;
	assign result = result_q;

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.gain <= 16'(UNITY))
		else $error("gain above unity");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching input transfer");

	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.gain == '0 |-> result.sample_out == '0)
		else $error("nonzero sample at zero gain");

endmodule
